// File: hw/rtl/m3p40_pkg.sv
`default_nettype none

package m3p40_pkg;

    localparam logic [63:0] MOD_M    = 64'd12157665459056928801;
    localparam logic [31:0] SPLIT_S  = 32'd3486784401;
    localparam logic [63:0] ALL_ONES = 64'd18446744073709551615;
    // floor(2^63 / 3^20), quotient estimate for division by 3^20
    localparam logic [31:0] RECIP_S  = 32'((64'd1 << 63) / {32'd0, SPLIT_S});

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_MUL = 3'd1;
    localparam logic [2:0] MODE_NEG = 3'd2;
    localparam logic [2:0] MODE_INV = 3'd3;
    localparam logic [2:0] MODE_VAL = 3'd4;

    // datapath operations
    localparam logic [4:0] OP_NOP       = 5'd0;
    localparam logic [4:0] OP_LOAD      = 5'd1;
    localparam logic [4:0] OP_ADD_AB    = 5'd2;
    localparam logic [4:0] OP_NEG_A     = 5'd3;
    localparam logic [4:0] OP_NEGA_TO_A = 5'd4;
    localparam logic [4:0] OP_DIV       = 5'd5;
    localparam logic [4:0] OP_SPLIT_X   = 5'd6;
    localparam logic [4:0] OP_SPLIT_Y   = 5'd7;
    localparam logic [4:0] OP_MUL       = 5'd8;
    localparam logic [4:0] OP_ACC_SET   = 5'd9;
    localparam logic [4:0] OP_ACC_ADD   = 5'd10;
    localparam logic [4:0] OP_NEG_ACC   = 5'd11;
    localparam logic [4:0] OP_LD_XY     = 5'd12;
    localparam logic [4:0] OP_U_ONE     = 5'd13;
    localparam logic [4:0] OP_U_ACC     = 5'd14;
    localparam logic [4:0] OP_ACC_U     = 5'd15;
    localparam logic [4:0] OP_A_QUOT    = 5'd16;

    // divider dividend source
    localparam logic [1:0] DSRC_A    = 2'd0;
    localparam logic [1:0] DSRC_X    = 2'd1;
    localparam logic [1:0] DSRC_Y    = 2'd2;
    localparam logic [1:0] DSRC_PROD = 2'd3;

    // multiplier operand pair
    localparam logic [1:0] MSEL_X0Y1 = 2'd0;
    localparam logic [1:0] MSEL_Y0X1 = 2'd1;
    localparam logic [1:0] MSEL_X0Y0 = 2'd2;
    localparam logic [1:0] MSEL_SREM = 2'd3;

    // multiply operand load
    localparam logic [1:0] XY_AB = 2'd0;
    localparam logic [1:0] XY_AU = 2'd1;
    localparam logic [1:0] XY_UW = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } t_in;

    typedef struct packed {
        logic [63:0] value;
        logic [5:0]  val_count;
        logic        is_zero;
        logic        not_invertible;
    } t_out;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] dsrc;
        logic       by3;
        logic [1:0] msel;
        logic [1:0] xysel;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic rem_zero;
        logic rem_two;
        logic a_zero;
    } t_stat;

    function automatic logic [63:0] red_m(input logic [63:0] x);
        logic [63:0] r;
        r = (x >= MOD_M) ? (x - MOD_M) : x;
        return r;
    endfunction

    function automatic logic [63:0] add_m(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, MOD_M}) begin
            s = s - {1'b0, MOD_M};
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] neg_m(input logic [63:0] x);
        logic [63:0] r;
        r = (x == 64'd0) ? 64'd0 : (MOD_M - x);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mod_3_pow_40_arith_unit.sv
`default_nettype none

// Arithmetic on 3-adic integers held modulo 3^40.
// Input: i_item (mode, operand_a, operand_b) is taken on a clock edge with
// start high and busy low. Both operands are reduced modulo 3^40 on entry.
// Output: o_result is valid for exactly one cycle while o_done is high; the
// receiver cannot hold it off, so it must take it in that cycle.
// One item at a time; busy stays high from the transfer until o_done.
// When o_done is raised depends on the mode; division by 3 or 3^20 goes
// through the shared divider, which multiply, inverse and valuation use:
//   add, negate, unused modes, valuation of zero: no division
//   multiply: one modular multiply
//   inverse: longer when operand_a is 2 mod 3; shorter when not invertible
//   valuation: grows with v, the valuation found
// busy falls in the cycle after o_done, so the next transfer can be taken
// at the end of that cycle; no new item is taken before o_done.
// Reset is synchronous, active low, and returns the block to idle; any
// item in progress is dropped without a result.

module mod_3_pow_40_arith_unit
    import m3p40_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_in  i_item,
    output logic      busy,
    output logic      o_done,
    output t_out      o_result
);

    t_cmd        cmd;
    t_stat       stat;
    logic [63:0] dp_value;
    logic [5:0]  dp_vc;
    logic        is_zero;
    logic        not_inv;

    m3p40_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_mode    (i_item.mode),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_is_zero (is_zero),
        .o_not_inv (not_inv)
    );

    m3p40_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_value     (dp_value),
        .o_val_count (dp_vc)
    );

    assign o_result.value          = dp_value & ALL_ONES;
    assign o_result.val_count      = dp_vc;
    assign o_result.is_zero        = is_zero;
    assign o_result.not_invertible = not_inv;

`ifndef SYNTH
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer taken but block not busy");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_done))
        else $error("busy dropped without a result");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.is_zero) |->
            (o_result.value == 64'd0 && o_result.val_count == 6'd0))
        else $error("zero valuation with non-zero fields");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/m3p40_div.sv
`default_nettype none

module m3p40_div
    import m3p40_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_by3,
    input  wire logic [63:0] i_dividend,
    output logic             o_done,
    output logic [63:0]      o_quot,
    output logic [31:0]      o_rem
);

    localparam logic [2:0] LAST_STEP = 3'd6;

    logic [63:0] r_x;
    logic [63:0] r_t;
    logic [32:0] r_f;
    logic [63:0] r_p;
    logic [31:0] r_q;
    logic [63:0] r_r;
    logic        r_by3;
    logic [2:0]  r_cnt;
    logic        r_run;
    logic        r_done;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [64:0] upper;
    logic [1:0]  rem3;

    // by 3^20: reciprocal estimate (low half, then high half of x * RECIP_S),
    // back-multiply, then two compare-and-subtract corrections
    always_comb begin
        case (r_cnt)
            3'd0:    begin mul_a = r_x[31:0];  mul_b = RECIP_S; end
            3'd1:    begin mul_a = r_x[63:32]; mul_b = RECIP_S; end
            default: begin mul_a = r_q;        mul_b = SPLIT_S; end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    assign upper = {1'b0, mul_p} + {33'd0, r_p[63:32]};

    // digit sum has folded down to at most 6
    always_comb begin
        if (r_f[2:0] >= 3'd6) begin
            rem3 = 2'd0;
        end else if (r_f[2:0] >= 3'd3) begin
            rem3 = 2'(r_f[2:0] - 3'd3);
        end else begin
            rem3 = r_f[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == LAST_STEP) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // by 3: remainder from folded digit sums (2^32, 2^16, 2^8, 16 and 4 are
    // all 1 mod 3); quotient is x * 3^-1 mod 2^64, exact when the remainder
    // is zero, built as -x * 0x5555555555555555 by shift-and-add
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_dividend;
            r_t   <= i_dividend;
            r_by3 <= i_by3;
        end else if (r_run) begin
            case (r_cnt)
                3'd0: begin
                    r_t <= r_t + {r_t[61:0], 2'd0};
                    r_f <= {1'b0, r_x[63:32]} + {1'b0, r_x[31:0]};
                    r_p <= mul_p;
                end
                3'd1: begin
                    r_t <= r_t + {r_t[59:0], 4'd0};
                    r_f <= {16'd0, r_f[32:16]} + {17'd0, r_f[15:0]};
                    r_q <= upper[62:31];
                end
                3'd2: begin
                    r_t <= r_t + {r_t[55:0], 8'd0};
                    r_f <= {23'd0, r_f[17:8]} + {25'd0, r_f[7:0]};
                    r_p <= mul_p;
                end
                3'd3: begin
                    r_t <= r_t + {r_t[47:0], 16'd0};
                    r_f <= {26'd0, r_f[10:4]} + {29'd0, r_f[3:0]};
                    r_r <= r_x - r_p;
                end
                3'd4: begin
                    r_t <= r_t + {r_t[31:0], 32'd0};
                    r_f <= {29'd0, r_f[7:4]} + {29'd0, r_f[3:0]};
                    if (r_r >= {32'd0, SPLIT_S}) begin
                        r_r <= r_r - {32'd0, SPLIT_S};
                        r_q <= r_q + 32'd1;
                    end
                end
                3'd5: begin
                    r_t <= 64'd0 - r_t;
                    r_f <= {30'd0, r_f[4:2]} + {31'd0, r_f[1:0]};
                    if (r_r >= {32'd0, SPLIT_S}) begin
                        r_r <= r_r - {32'd0, SPLIT_S};
                        r_q <= r_q + 32'd1;
                    end
                end
                default: begin
                    r_f <= {31'd0, r_f[3:2]} + {31'd0, r_f[1:0]};
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_by3 ? r_t : {32'd0, r_q};
    assign o_rem  = r_by3 ? {30'd0, rem3} : r_r[31:0];

endmodule

`default_nettype wire

// File: hw/rtl/m3p40_dpath.sv
`default_nettype none

module m3p40_dpath
    import m3p40_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_in         i_item,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    output logic [63:0]      o_value,
    output logic [5:0]       o_val_count
);

    logic [63:0] r_a, r_b, r_x, r_y, r_prod, r_acc, r_u;
    logic [31:0] r_x0, r_x1, r_y0, r_y1;
    logic [5:0]  r_vc;

    logic [63:0] div_in, div_quot;
    logic [31:0] div_rem;
    logic        div_done;
    logic        div_start;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    assign div_start = (i_cmd.op == OP_DIV);

    always_comb begin
        case (i_cmd.dsrc)
            DSRC_A:  div_in = r_a;
            DSRC_X:  div_in = r_x;
            DSRC_Y:  div_in = r_y;
            default: div_in = r_prod;
        endcase
    end

    m3p40_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_by3      (i_cmd.by3),
        .i_dividend (div_in),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        case (i_cmd.msel)
            MSEL_X0Y1: begin mul_a = r_x0;    mul_b = r_y1;    end
            MSEL_Y0X1: begin mul_a = r_y0;    mul_b = r_x1;    end
            MSEL_X0Y0: begin mul_a = r_x0;    mul_b = r_y0;    end
            default:   begin mul_a = SPLIT_S; mul_b = div_rem; end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_a   <= red_m(i_item.operand_a);
                r_b   <= red_m(i_item.operand_b);
                r_acc <= '0;
                r_vc  <= '0;
            end
            OP_ADD_AB:    r_acc <= add_m(r_a, r_b);
            OP_NEG_A:     r_acc <= neg_m(r_a);
            OP_NEGA_TO_A: r_a   <= neg_m(r_a);
            OP_SPLIT_X: begin
                r_x0 <= div_rem;
                r_x1 <= div_quot[31:0];
            end
            OP_SPLIT_Y: begin
                r_y0 <= div_rem;
                r_y1 <= div_quot[31:0];
            end
            OP_MUL:     r_prod <= mul_p;
            OP_ACC_SET: r_acc  <= r_prod;
            OP_ACC_ADD: r_acc  <= add_m(r_acc, r_prod);
            OP_NEG_ACC: r_acc  <= neg_m(r_acc);
            OP_LD_XY: begin
                case (i_cmd.xysel)
                    XY_AB: begin r_x <= r_a; r_y <= r_b; end
                    XY_AU: begin r_x <= r_a; r_y <= r_u; end
                    default: begin
                        // w = 2 - x*u, acc already negated
                        r_x <= r_u;
                        r_y <= add_m(64'd2, r_acc);
                    end
                endcase
            end
            OP_U_ONE: r_u   <= 64'd1;
            OP_U_ACC: r_u   <= r_acc;
            OP_ACC_U: r_acc <= r_u;
            OP_A_QUOT: begin
                r_a  <= div_quot;
                r_vc <= r_vc + 6'd1;
            end
            default: ;
        endcase
    end

    assign o_stat.div_done = div_done;
    assign o_stat.rem_zero = (div_rem == 32'd0);
    assign o_stat.rem_two  = (div_rem == 32'd2);
    assign o_stat.a_zero   = (r_a == 64'd0);
    assign o_value         = r_acc;
    assign o_val_count     = r_vc;

endmodule

`default_nettype wire

// File: hw/rtl/m3p40_ctrl.sv
`default_nettype none

module m3p40_ctrl
    import m3p40_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [2:0] i_mode,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd,
    output logic            o_busy,
    output logic            o_done,
    output logic            o_is_zero,
    output logic            o_not_inv
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISP     = 5'd1;
    localparam logic [4:0] S_INV_W    = 5'd2;
    localparam logic [4:0] S_INV_INIT = 5'd3;
    localparam logic [4:0] S_NT1      = 5'd4;
    localparam logic [4:0] S_NT2      = 5'd5;
    localparam logic [4:0] S_NT3      = 5'd6;
    localparam logic [4:0] S_NT4      = 5'd7;
    localparam logic [4:0] S_INV_FIN  = 5'd8;
    localparam logic [4:0] S_INV_NEG  = 5'd9;
    localparam logic [4:0] S_VAL_W    = 5'd10;
    localparam logic [4:0] S_VAL_GO   = 5'd11;
    localparam logic [4:0] S_MDX      = 5'd12;
    localparam logic [4:0] S_MDXW     = 5'd13;
    localparam logic [4:0] S_MDY      = 5'd14;
    localparam logic [4:0] S_MDYW     = 5'd15;
    localparam logic [4:0] S_MP0      = 5'd16;
    localparam logic [4:0] S_MD0      = 5'd17;
    localparam logic [4:0] S_MD0W     = 5'd18;
    localparam logic [4:0] S_MC0      = 5'd19;
    localparam logic [4:0] S_MA0      = 5'd20;
    localparam logic [4:0] S_MP1      = 5'd21;
    localparam logic [4:0] S_MD1      = 5'd22;
    localparam logic [4:0] S_MD1W     = 5'd23;
    localparam logic [4:0] S_MC1      = 5'd24;
    localparam logic [4:0] S_MA1      = 5'd25;
    localparam logic [4:0] S_MP2      = 5'd26;
    localparam logic [4:0] S_MA2      = 5'd27;
    localparam logic [4:0] S_DONE     = 5'd28;

    localparam logic [1:0] RET_MULT = 2'd0;
    localparam logic [1:0] RET_NT2  = 2'd1;
    localparam logic [1:0] RET_NT4  = 2'd2;

    logic [4:0] r_state, n_state;
    logic [2:0] r_mode, n_mode;
    logic [1:0] r_ret, n_ret;
    logic [2:0] r_iter, n_iter;
    logic       r_zf, n_zf;
    logic       r_ni, n_ni;
    logic       r_neg, n_neg;

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_ret   = r_ret;
        n_iter  = r_iter;
        n_zf    = r_zf;
        n_ni    = r_ni;
        n_neg   = r_neg;
        o_cmd   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_mode   = i_mode;
                    n_zf     = 1'b0;
                    n_ni     = 1'b0;
                    n_neg    = 1'b0;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                case (r_mode)
                    MODE_ADD: begin
                        o_cmd.op = OP_ADD_AB;
                        n_state  = S_DONE;
                    end
                    MODE_MUL: begin
                        o_cmd.op    = OP_LD_XY;
                        o_cmd.xysel = XY_AB;
                        n_ret       = RET_MULT;
                        n_state     = S_MDX;
                    end
                    MODE_NEG: begin
                        o_cmd.op = OP_NEG_A;
                        n_state  = S_DONE;
                    end
                    MODE_INV: begin
                        o_cmd.op   = OP_DIV;
                        o_cmd.dsrc = DSRC_A;
                        o_cmd.by3  = 1'b1;
                        n_state    = S_INV_W;
                    end
                    MODE_VAL: begin
                        if (i_stat.a_zero) begin
                            n_zf    = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.op   = OP_DIV;
                            o_cmd.dsrc = DSRC_A;
                            o_cmd.by3  = 1'b1;
                            n_state    = S_VAL_W;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_INV_W: begin
                if (i_stat.div_done) begin
                    if (i_stat.rem_zero) begin
                        n_ni    = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        // a = 2 mod 3: iterate on -a and negate at the end
                        if (i_stat.rem_two) begin
                            o_cmd.op = OP_NEGA_TO_A;
                            n_neg    = 1'b1;
                        end
                        n_state = S_INV_INIT;
                    end
                end
            end
            S_INV_INIT: begin
                o_cmd.op = OP_U_ONE;
                n_iter   = '0;
                n_state  = S_NT1;
            end
            S_NT1: begin
                o_cmd.op    = OP_LD_XY;
                o_cmd.xysel = XY_AU;
                n_ret       = RET_NT2;
                n_state     = S_MDX;
            end
            S_NT2: begin
                o_cmd.op = OP_NEG_ACC;
                n_state  = S_NT3;
            end
            S_NT3: begin
                o_cmd.op    = OP_LD_XY;
                o_cmd.xysel = XY_UW;
                n_ret       = RET_NT4;
                n_state     = S_MDX;
            end
            S_NT4: begin
                o_cmd.op = OP_U_ACC;
                n_iter   = r_iter + 3'd1;
                n_state  = (r_iter == 3'd5) ? S_INV_FIN : S_NT1;
            end
            S_INV_FIN: begin
                o_cmd.op = OP_ACC_U;
                n_state  = r_neg ? S_INV_NEG : S_DONE;
            end
            S_INV_NEG: begin
                o_cmd.op = OP_NEG_ACC;
                n_state  = S_DONE;
            end
            S_VAL_W: begin
                if (i_stat.div_done) begin
                    if (i_stat.rem_zero) begin
                        o_cmd.op = OP_A_QUOT;
                        n_state  = S_VAL_GO;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_VAL_GO: begin
                o_cmd.op   = OP_DIV;
                o_cmd.dsrc = DSRC_A;
                o_cmd.by3  = 1'b1;
                n_state    = S_VAL_W;
            end
            // modular multiply x*y, result in acc
            S_MDX: begin
                o_cmd.op   = OP_DIV;
                o_cmd.dsrc = DSRC_X;
                n_state    = S_MDXW;
            end
            S_MDXW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_SPLIT_X;
                    n_state  = S_MDY;
                end
            end
            S_MDY: begin
                o_cmd.op   = OP_DIV;
                o_cmd.dsrc = DSRC_Y;
                n_state    = S_MDYW;
            end
            S_MDYW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_SPLIT_Y;
                    n_state  = S_MP0;
                end
            end
            S_MP0: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MSEL_X0Y1;
                n_state    = S_MD0;
            end
            S_MD0: begin
                o_cmd.op   = OP_DIV;
                o_cmd.dsrc = DSRC_PROD;
                n_state    = S_MD0W;
            end
            S_MD0W: begin
                if (i_stat.div_done) begin
                    n_state = S_MC0;
                end
            end
            S_MC0: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MSEL_SREM;
                n_state    = S_MA0;
            end
            S_MA0: begin
                o_cmd.op = OP_ACC_SET;
                n_state  = S_MP1;
            end
            S_MP1: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MSEL_Y0X1;
                n_state    = S_MD1;
            end
            S_MD1: begin
                o_cmd.op   = OP_DIV;
                o_cmd.dsrc = DSRC_PROD;
                n_state    = S_MD1W;
            end
            S_MD1W: begin
                if (i_stat.div_done) begin
                    n_state = S_MC1;
                end
            end
            S_MC1: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MSEL_SREM;
                n_state    = S_MA1;
            end
            S_MA1: begin
                o_cmd.op = OP_ACC_ADD;
                n_state  = S_MP2;
            end
            S_MP2: begin
                o_cmd.op   = OP_MUL;
                o_cmd.msel = MSEL_X0Y0;
                n_state    = S_MA2;
            end
            S_MA2: begin
                o_cmd.op = OP_ACC_ADD;
                case (r_ret)
                    RET_NT2: n_state = S_NT2;
                    RET_NT4: n_state = S_NT4;
                    default: n_state = S_DONE;
                endcase
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_zf    <= 1'b0;
            r_ni    <= 1'b0;
            r_neg   <= 1'b0;
            r_iter  <= '0;
            r_ret   <= RET_MULT;
            r_mode  <= MODE_ADD;
        end else begin
            r_state <= n_state;
            r_zf    <= n_zf;
            r_ni    <= n_ni;
            r_neg   <= n_neg;
            r_iter  <= n_iter;
            r_ret   <= n_ret;
            r_mode  <= n_mode;
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = (r_state == S_DONE);
    assign o_is_zero = r_zf;
    assign o_not_inv = r_ni;

endmodule

`default_nettype wire

// File: tb/mod_3_pow_40_arith_unit_chk.sv
`default_nettype none

module mod_3_pow_40_arith_unit_chk
    import m3p40_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_busy,
    input  wire t_in  i_item,
    input  wire logic i_done,
    input  wire t_out i_result,
    output int        o_errors,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [127:0] MODULUS = {64'd0, MOD_M};

    t_out awaited_q[$];
    int   nresults;

    function automatic logic [63:0] mulmod(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return 64'(p % MODULUS);
    endfunction

    function automatic logic [63:0] addmod(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] s;
        s = {64'd0, x} + {64'd0, y};
        return 64'(s % MODULUS);
    endfunction

    function automatic logic [63:0] negmod(input logic [63:0] x);
        return (x == 64'd0) ? 64'd0 : MOD_M - x;
    endfunction

    // x must be 1 mod 3
    function automatic logic [63:0] newton_recip(input logic [63:0] x);
        logic [63:0] u;
        u = 64'd1;
        for (int i = 0; i < 6; i++) begin
            u = mulmod(u, addmod(64'd2, negmod(mulmod(x, u))));
        end
        return u;
    endfunction

    function automatic t_out padic_result(input t_in it);
        t_out        r;
        logic [63:0] a, b;
        r = '0;
        a = 64'({64'd0, it.operand_a} % MODULUS);
        b = 64'({64'd0, it.operand_b} % MODULUS);
        case (it.mode)
            MODE_ADD: r.value = addmod(a, b);
            MODE_MUL: r.value = mulmod(a, b);
            MODE_NEG: r.value = negmod(a);
            MODE_INV: begin
                if (a % 64'd3 == 64'd1) begin
                    r.value = newton_recip(a);
                end else if (a % 64'd3 == 64'd2) begin
                    r.value = negmod(newton_recip(negmod(a)));
                end else begin
                    r.not_invertible = 1'b1;
                end
            end
            MODE_VAL: begin
                if (a == 64'd0) begin
                    r.is_zero = 1'b1;
                end else begin
                    while (a % 64'd3 == 64'd0) begin
                        a = a / 64'd3;
                        r.val_count = r.val_count + 6'd1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] mismatch on result %0d: %s got %0d expected %0d",
                 $realtime, nresults, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
        nresults  = 0;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_done) begin
                if (awaited_q.size() == 0) begin
                    report("unexpected transfer, value", i_result.value, 64'd0);
                end else begin
                    want = awaited_q.pop_front();
                    if (i_result.value !== want.value)
                        report("value", i_result.value, want.value);
                    if (i_result.val_count !== want.val_count)
                        report("val_count", 64'(i_result.val_count), 64'(want.val_count));
                    if (i_result.is_zero !== want.is_zero)
                        report("is_zero", 64'(i_result.is_zero), 64'(want.is_zero));
                    if (i_result.not_invertible !== want.not_invertible)
                        report("not_invertible", 64'(i_result.not_invertible),
                               64'(want.not_invertible));
                end
                nresults++;
            end
            if (i_start && !i_busy)
                awaited_q.push_back(padic_result(i_item));
            o_pending = awaited_q.size();
        end
    end

endmodule

`default_nettype wire

// File: tb/mod_3_pow_40_arith_unit_tb.sv
`default_nettype none

module mod_3_pow_40_arith_unit_tb;
    import m3p40_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_item  = '0;
    logic busy;
    logic o_done;
    t_out o_result;
    int   errors;
    int   pending;
    int   mode_cnt[8];

    mod_3_pow_40_arith_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    mod_3_pow_40_arith_unit_chk i_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_item    (i_item),
        .i_done    (o_done),
        .i_result  (o_result),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", pending);
        $display("mod_3_pow_40_arith_unit_tb: FAIL");
        $finish;
    end

    function automatic logic [63:0] pow3(input int k);
        logic [63:0] p;
        p = 64'd1;
        repeat (k) p = p * 64'd3;
        return p;
    endfunction

    function automatic logic [63:0] rnd64();
        logic [63:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 20));
            1: return MOD_M - 64'($urandom_range(0, 20));
            2: return MOD_M + 64'($urandom_range(0, 20));
            3: return ALL_ONES - 64'($urandom_range(0, 20));
            default: return full;
        endcase
    endfunction

    function automatic logic [63:0] val_operand();
        logic [63:0] a;
        int          k;
        k = $urandom_range(0, 39);
        a = pow3(k) * 64'($urandom_range(1, 50));
        if ($urandom_range(0, 7) == 0)
            a = 64'($urandom_range(0, 1)) * MOD_M;
        return a;
    endfunction

    function automatic t_in random_item();
        t_in it;
        int  pick;
        pick = $urandom_range(0, 99);
        it.operand_a = rnd64();
        it.operand_b = rnd64();
        if (pick < 22)      it.mode = MODE_ADD;
        else if (pick < 50) it.mode = MODE_MUL;
        else if (pick < 65) it.mode = MODE_NEG;
        else if (pick < 76) it.mode = MODE_INV;
        else if (pick < 95) it.mode = MODE_VAL;
        else                it.mode = 3'($urandom_range(5, 7));
        if (it.mode == MODE_VAL && $urandom_range(0, 3) != 0)
            it.operand_a = val_operand();
        return it;
    endfunction

    // transfer happens at the first edge with busy low; busy is sampled mid-cycle
    task automatic issue(input t_in it);
        int gap;
        start  <= 1'b1;
        i_item <= it;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
        mode_cnt[it.mode]++;
        gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 40);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_in mk(input logic [2:0] m, input logic [63:0] a,
                               input logic [63:0] b);
        t_in it;
        it.mode      = m;
        it.operand_a = a;
        it.operand_b = b;
        return it;
    endfunction

    initial begin
        t_in directed[$];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(mk(MODE_ADD, 64'd0, 64'd0));
        directed.push_back(mk(MODE_ADD, MOD_M - 64'd1, MOD_M - 64'd1));
        directed.push_back(mk(MODE_ADD, ALL_ONES, ALL_ONES));
        directed.push_back(mk(MODE_MUL, ALL_ONES, ALL_ONES));
        directed.push_back(mk(MODE_MUL, MOD_M - 64'd1, MOD_M - 64'd1));
        directed.push_back(mk(MODE_MUL, MOD_M, 64'd7));
        directed.push_back(mk(MODE_NEG, 64'd0, ALL_ONES));
        directed.push_back(mk(MODE_NEG, MOD_M, 64'd0));
        directed.push_back(mk(MODE_NEG, 64'd1, 64'd0));
        directed.push_back(mk(MODE_INV, 64'd1, 64'd0));
        directed.push_back(mk(MODE_INV, 64'd2, 64'd0));
        directed.push_back(mk(MODE_INV, 64'd0, 64'd0));
        directed.push_back(mk(MODE_INV, 64'd3, 64'd0));
        directed.push_back(mk(MODE_INV, MOD_M - 64'd1, 64'd0));
        directed.push_back(mk(MODE_INV, ALL_ONES, 64'd0));
        directed.push_back(mk(MODE_VAL, 64'd0, 64'd0));
        directed.push_back(mk(MODE_VAL, MOD_M, 64'd0));
        directed.push_back(mk(MODE_VAL, pow3(39), 64'd0));
        directed.push_back(mk(MODE_VAL, pow3(39) * 64'd2, 64'd0));
        directed.push_back(mk(MODE_VAL, 64'd1, 64'd0));
        directed.push_back(mk(MODE_VAL, ALL_ONES, 64'd0));
        directed.push_back(mk(3'd5, ALL_ONES, ALL_ONES));
        directed.push_back(mk(3'd6, 64'd1, 64'd2));
        directed.push_back(mk(3'd7, ALL_ONES, 64'd0));
        foreach (directed[i]) issue(directed[i]);

        repeat (1350) issue(random_item());
        start <= 1'b0;

        wait (pending == 0);
        repeat (50) @(posedge i_clk);

        $display("covered: add %0d, mul %0d, neg %0d, inv %0d, val %0d, unused %0d",
                 mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3], mode_cnt[4],
                 mode_cnt[5] + mode_cnt[6] + mode_cnt[7]);
        $display("operands spanned raw 64-bit values, values around 3^40 and powers of 3");
        if (errors == 0 && pending == 0) begin
            $display("mod_3_pow_40_arith_unit_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending);
            $display("mod_3_pow_40_arith_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
